// ===== hw/rtl/fro_pkg.sv =====
// Shared types, codes, sizes and the fog table for the fragment raster back end.
package fro_pkg;

  localparam int BUFFER_WIDTH    = 256;
  localparam int BUFFER_HEIGHT   = 256;
  localparam int FOG_TABLE_DEPTH = 256;
  localparam int PIXELS          = BUFFER_WIDTH * BUFFER_HEIGHT;
  localparam int PIX_W           = $clog2(PIXELS);
  localparam int FOG_AW          = $clog2(FOG_TABLE_DEPTH);
  // signed linear index before the bounds check
  localparam int IDX_CW          = 28;

  localparam logic [23:0] DEPTH_ONE = 24'hFFFFFF;

  // control register bit positions
  localparam int CTL_SCISSOR = 0;
  localparam int CTL_DTEST   = 1;
  localparam int CTL_DWRITE  = 2;
  localparam int CTL_FOG     = 3;
  localparam int CTL_BLEND   = 4;

  typedef enum logic [1:0] {
    ACT_FRAG  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } fro_action_t;

  typedef enum logic [2:0] {
    ST_WRITTEN = 3'd0,
    ST_SCISSOR = 3'd1,
    ST_OOB     = 3'd2,
    ST_DFAIL   = 3'd3,
    ST_CLEARED = 3'd4,
    ST_READ    = 3'd5
  } fro_status_t;

  typedef enum logic [2:0] {
    DF_NEVER    = 3'd0,
    DF_LESS     = 3'd1,
    DF_EQUAL    = 3'd2,
    DF_LEQUAL   = 3'd3,
    DF_GREATER  = 3'd4,
    DF_NOTEQUAL = 3'd5,
    DF_GEQUAL   = 3'd6,
    DF_ALWAYS   = 3'd7
  } fro_dfunc_t;

  typedef enum logic [1:0] {
    FOG_LINEAR  = 2'd0,
    FOG_EXP     = 2'd1,
    FOG_EXP2    = 2'd2,
    FOG_LINEAR2 = 2'd3
  } fro_fogmode_t;

  typedef enum logic [3:0] {
    REG_VP_ORIGIN   = 4'd0,
    REG_VP_SIZE     = 4'd1,
    REG_CONTROL     = 4'd2,
    REG_FOG_START   = 4'd3,
    REG_FOG_END     = 4'd4,
    REG_FOG_DENSITY = 4'd5,
    REG_FOG_COLOR   = 4'd6,
    REG_CLEAR_COLOR = 4'd7
  } fro_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDR,
    S_LOOK,
    S_TEST,
    S_FOG_MUL1,
    S_FOG_MUL2,
    S_FOG_LOOK,
    S_DIV,
    S_FOG_MIX,
    S_BLEND,
    S_WRITE,
    S_READ,
    S_CLR_RD,
    S_CLR_WR
  } fro_state_t;

  typedef logic [FOG_TABLE_DEPTH-1:0][16:0] fog_table_t;

  // exp(-16 i / depth) in Q1.16, from a truncated series and repeated products
  function automatic fog_table_t build_fog_table();
    fog_table_t  tab;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] p;
    t    = (64'd16 << 32) / 64'(FOG_TABLE_DEPTH);
    term = 64'd1 << 32;
    sum  = 64'd1 << 32;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * t) >> 32) / 64'(k);
      if (k % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    p = 64'd1 << 32;
    for (int i = 0; i < FOG_TABLE_DEPTH; i++) begin
      tab[i] = 17'((p + (64'd1 << 15)) >> 16);
      p      = (p * sum + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam fog_table_t FOG_TABLE = build_fog_table();

endpackage

// ===== hw/rtl/fragment_raster_operations.sv =====
// Fragment raster back end: scissor, bounds, depth test, fog, blend, clear and readback.
// Linear fog takes a 16-step divide; each channel mix uses the one shared multiplier.
// Clear covers all 65536 pixels: a read state then a write state per pixel for depth
// only, and with colour read, three channel mixes and write per pixel.
// busy stays high for the whole item; the result strobe lasts one cycle, no stall.
// Reset (synchronous, rst_n low) clears control, viewport, fog start and colours, sets
// fog end and density to all ones; the captured word and stores are not cleared.
module fragment_raster_operations (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_action,
  input  logic signed [11:0]        in_pos_x,
  input  logic signed [11:0]        in_pos_y,
  input  logic [23:0]               in_depth,
  input  logic [7:0]                in_red,
  input  logic [7:0]                in_green,
  input  logic [7:0]                in_blue,
  input  logic [7:0]                in_alpha,
  input  logic [1:0]                in_clear_mask,
  output logic                      out_valid,
  output logic [2:0]                out_status,
  output logic [23:0]               out_read_color,
  output logic [23:0]               out_read_depth,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [3:0]                cfg_index,
  input  logic [31:0]               cfg_data
);
  import fro_pkg::*;

  fro_state_t state_r, state_nxt;

  // configuration
  logic [23:0] vp_origin_r, vp_size_r, fog_start_r, fog_end_r;
  logic [9:0]  control_r;
  logic [15:0] fog_density_r;
  logic [31:0] fog_color_r, clear_color_r;

  // captured word
  fro_action_t act_r;
  logic [11:0] px_r, py_r;
  logic [23:0] z_r;
  logic [1:0]  mask_r;
  logic [7:0]  col_r [4];
  logic [7:0]  col_nxt [4];
  logic [7:0]  mix_r [3];
  logic [7:0]  mix_nxt [3];

  // sequencer datapath
  logic [PIX_W-1:0] idx_r, idx_nxt;
  logic [PIX_W-1:0] cursor_r, cursor_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             ph_r, ph_nxt;
  logic [16:0]      f_r, f_nxt;
  logic [23:0]      rem_r, rem_nxt;
  logic [23:0]      div_r, div_nxt;
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod_r;

  // stores
  logic [23:0] color_mem [PIXELS];
  logic [23:0] depth_mem [PIXELS];
  logic [23:0] color_rd_r, depth_rd_r;
  logic             mem_rd;
  logic [PIX_W-1:0] mem_ra, mem_wa;
  logic             color_we, depth_we;
  logic [23:0]      color_wd, depth_wd;

  // result
  logic        fin;
  fro_status_t fin_status;
  logic [23:0] fin_color, fin_depth;
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [23:0] out_color_r, out_depth_r;

  // address arithmetic
  logic signed [13:0]       sx, sy;
  logic signed [IDX_CW-1:0] lin;
  logic                     oob, scis_fail;

  // fog and mix helpers
  logic [59:0] fog_scaled;
  logic [23:0] fog_idx;
  logic [24:0] div_t;
  logic        div_ge;
  logic [1:0]  k;
  logic [7:0]  ch_c, ch_d, ch_fc, ch_a;
  logic signed [8:0]  ch_diff;
  logic signed [26:0] fog_sum;
  logic signed [18:0] bl_v;
  logic [17:0]        bl_q;
  logic               clearing;
  fro_dfunc_t         dfunc;
  fro_fogmode_t       fmode;

  function automatic logic depth_pass(fro_dfunc_t fn, logic [23:0] nz, logic [23:0] oz);
    logic p;
    unique case (fn)
      DF_NEVER:    p = 1'b0;
      DF_LESS:     p = nz < oz;
      DF_EQUAL:    p = nz == oz;
      DF_LEQUAL:   p = nz <= oz;
      DF_GREATER:  p = nz > oz;
      DF_NOTEQUAL: p = nz != oz;
      DF_GEQUAL:   p = nz >= oz;
      DF_ALWAYS:   p = 1'b1;
      default:     p = 1'b1;
    endcase
    return p;
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_color = out_color_r;
  assign out_read_depth = out_depth_r;

  assign clearing = (act_r == ACT_CLEAR);
  assign dfunc    = fro_dfunc_t'(control_r[7:5]);
  assign fmode    = fro_fogmode_t'(control_r[9:8]);

  assign sx  = $signed({{2{px_r[11]}}, px_r}) + $signed({2'b00, vp_origin_r[11:0]});
  assign sy  = $signed({{2{py_r[11]}}, py_r}) + $signed({2'b00, vp_origin_r[23:12]});
  assign lin = IDX_CW'(sx) + IDX_CW'(sy) * $signed(IDX_CW'(BUFFER_WIDTH));
  assign oob = (lin < 0) || (lin >= $signed(IDX_CW'(PIXELS)));
  assign scis_fail = px_r[11] || (px_r >= vp_size_r[11:0]) ||
                     py_r[11] || (py_r >= vp_size_r[23:12]);

  assign fog_scaled = {12'b0, prod_r[47:0]} * 60'(FOG_TABLE_DEPTH);
  assign fog_idx    = fog_scaled[59:36];

  assign div_t  = {rem_r, 1'b0};
  assign div_ge = div_t >= {1'b0, div_r};

  // channel operands for the mix steps
  assign k     = cnt_r[1:0];
  assign ch_fc = fog_color_r[31 - 8*k -: 8];
  assign ch_d  = color_rd_r[23 - 8*k -: 8];
  assign ch_c  = (state_r == S_FOG_MIX) ? col_r[k] :
                 clearing ? clear_color_r[31 - 8*k -: 8] : col_r[k];
  assign ch_a  = clearing ? clear_color_r[7:0] : col_r[3];
  assign ch_diff = (state_r == S_FOG_MIX) ? $signed({1'b0, ch_c}) - $signed({1'b0, ch_fc})
                                          : $signed({1'b0, ch_c}) - $signed({1'b0, ch_d});
  assign fog_sum = $signed({3'b000, ch_fc, 16'h0000}) + $signed(prod_r[26:0]) +
                   27'sd32768;
  assign bl_v = $signed({3'b000, ch_d, 8'h00}) - $signed({11'b0, ch_d}) +
                $signed(prod_r[18:0]) + 19'sd127;
  assign bl_q = {1'b0, bl_v[16:0]} + 18'd1 + {9'b0, bl_v[16:8]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cursor_r <= '0;
      cnt_r    <= '0;
      ph_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      cnt_r    <= cnt_nxt;
      ph_r     <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_origin_r   <= '0;
      vp_size_r     <= '0;
      control_r     <= '0;
      fog_start_r   <= '0;
      fog_end_r     <= DEPTH_ONE;
      fog_density_r <= 16'hFFFF;
      fog_color_r   <= '0;
      clear_color_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (fro_reg_t'(cfg_index))
        REG_VP_ORIGIN:   vp_origin_r   <= cfg_data[23:0];
        REG_VP_SIZE:     vp_size_r     <= cfg_data[23:0];
        REG_CONTROL:     control_r     <= cfg_data[9:0];
        REG_FOG_START:   fog_start_r   <= cfg_data[23:0];
        REG_FOG_END:     fog_end_r     <= cfg_data[23:0];
        REG_FOG_DENSITY: fog_density_r <= cfg_data[15:0];
        REG_FOG_COLOR:   fog_color_r   <= cfg_data;
        REG_CLEAR_COLOR: clear_color_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the word and hold datapath values
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_r  <= fro_action_t'(in_action);
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      z_r    <= in_depth;
      mask_r <= in_clear_mask;
      col_r[0] <= in_red;
      col_r[1] <= in_green;
      col_r[2] <= in_blue;
      col_r[3] <= in_alpha;
    end else begin
      col_r <= col_nxt;
    end
    mix_r  <= mix_nxt;
    idx_r  <= idx_nxt;
    f_r    <= f_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (color_we) color_mem[mem_wa] <= color_wd;
    if (depth_we) depth_mem[mem_wa] <= depth_wd;
    if (mem_rd) begin
      color_rd_r <= color_mem[mem_ra];
      depth_rd_r <= depth_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_status_r <= ST_WRITTEN;
      out_color_r  <= '0;
      out_depth_r  <= '0;
    end else begin
      out_valid_r <= fin;
      if (fin) begin
        out_status_r <= fin_status;
        out_color_r  <= fin_color;
        out_depth_r  <= fin_depth;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cursor_nxt = cursor_r;
    cnt_nxt    = cnt_r;
    ph_nxt     = ph_r;
    idx_nxt    = idx_r;
    f_nxt      = f_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    col_nxt    = col_r;
    mix_nxt    = mix_r;
    mul_a      = '0;
    mul_b      = '0;
    mem_rd     = 1'b0;
    mem_ra     = idx_r;
    mem_wa     = idx_r;
    color_we   = 1'b0;
    depth_we   = 1'b0;
    color_wd   = {col_r[0], col_r[1], col_r[2]};
    depth_wd   = z_r;
    fin        = 1'b0;
    fin_status = ST_WRITTEN;
    fin_color  = '0;
    fin_depth  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cursor_nxt = '0;
          state_nxt  = (fro_action_t'(in_action) == ACT_CLEAR) ? S_CLR_RD : S_ADDR;
        end
      end

      S_ADDR: begin
        idx_nxt = lin[PIX_W-1:0];
        priority if (act_r == ACT_NONE || act_r == ACT_CLEAR) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else if (act_r == ACT_FRAG && control_r[CTL_SCISSOR] && scis_fail) begin
          fin        = 1'b1;
          fin_status = ST_SCISSOR;
          state_nxt  = S_IDLE;
        end else if (oob) begin
          fin        = 1'b1;
          fin_status = ST_OOB;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        mem_rd    = 1'b1;
        state_nxt = (act_r == ACT_READ) ? S_READ : S_TEST;
      end

      S_READ: begin
        fin        = 1'b1;
        fin_status = ST_READ;
        fin_color  = color_rd_r;
        fin_depth  = depth_rd_r;
        state_nxt  = S_IDLE;
      end

      S_TEST: begin
        cnt_nxt = '0;
        ph_nxt  = 1'b0;
        priority if (control_r[CTL_DTEST] && !depth_pass(dfunc, z_r, depth_rd_r)) begin
          fin        = 1'b1;
          fin_status = ST_DFAIL;
          state_nxt  = S_IDLE;
        end else if (control_r[CTL_FOG] && (z_r > fog_start_r)) begin
          priority if (fmode == FOG_EXP || fmode == FOG_EXP2) begin
            state_nxt = S_FOG_MUL1;
          end else if (fog_end_r < fog_start_r) begin
            f_nxt     = 17'h10000;
            state_nxt = S_FOG_MIX;
          end else if (fog_end_r == fog_start_r || z_r >= fog_end_r) begin
            f_nxt     = '0;
            state_nxt = S_FOG_MIX;
          end else begin
            // quotient stays below one since fog_start < z < fog_end
            rem_nxt   = fog_end_r - z_r;
            div_nxt   = fog_end_r - fog_start_r;
            f_nxt     = '0;
            state_nxt = S_DIV;
          end
        end else begin
          state_nxt = control_r[CTL_BLEND] ? S_BLEND : S_WRITE;
        end
      end

      S_FOG_MUL1: begin
        mul_a     = $signed({9'b0, fog_density_r});
        mul_b     = $signed({1'b0, z_r});
        state_nxt = (fmode == FOG_EXP2) ? S_FOG_MUL2 : S_FOG_LOOK;
      end

      S_FOG_MUL2: begin
        mul_a     = $signed({1'b0, prod_r[39:16]});
        mul_b     = $signed({1'b0, prod_r[39:16]});
        state_nxt = S_FOG_LOOK;
      end

      S_FOG_LOOK: begin
        f_nxt     = (fog_idx >= 24'(FOG_TABLE_DEPTH)) ? 17'd0 :
                    FOG_TABLE[fog_idx[FOG_AW-1:0]];
        state_nxt = S_FOG_MIX;
      end

      S_DIV: begin
        if (div_ge) rem_nxt = 24'(div_t - {1'b0, div_r});
        else        rem_nxt = div_t[23:0];
        f_nxt   = {f_r[15:0], div_ge};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          cnt_nxt   = '0;
          state_nxt = S_FOG_MIX;
        end
      end

      S_FOG_MIX: begin
        if (!ph_r) begin
          mul_a  = 25'(ch_diff);
          mul_b  = $signed({8'b0, f_r});
          ph_nxt = 1'b1;
        end else begin
          col_nxt[k] = fog_sum[23:16];
          ph_nxt     = 1'b0;
          cnt_nxt    = cnt_r + 4'd1;
          if (cnt_r == 4'd3) begin
            cnt_nxt   = '0;
            state_nxt = control_r[CTL_BLEND] ? S_BLEND : S_WRITE;
          end
        end
      end

      S_BLEND: begin
        if (!ph_r) begin
          mul_a  = 25'(ch_diff);
          mul_b  = $signed({17'b0, ch_a});
          ph_nxt = 1'b1;
        end else begin
          mix_nxt[k] = bl_q[15:8];
          ph_nxt     = 1'b0;
          cnt_nxt    = cnt_r + 4'd1;
          if (cnt_r == 4'd2) begin
            cnt_nxt   = '0;
            state_nxt = clearing ? S_CLR_WR : S_WRITE;
          end
        end
      end

      S_WRITE: begin
        color_we   = 1'b1;
        depth_we   = control_r[CTL_DWRITE];
        if (control_r[CTL_BLEND]) color_wd = {mix_r[0], mix_r[1], mix_r[2]};
        fin        = 1'b1;
        state_nxt  = S_IDLE;
      end

      S_CLR_RD: begin
        cnt_nxt = '0;
        ph_nxt  = 1'b0;
        mem_ra  = cursor_r;
        if (mask_r[0]) begin
          mem_rd    = 1'b1;
          state_nxt = S_BLEND;
        end else begin
          state_nxt = S_CLR_WR;
        end
      end

      S_CLR_WR: begin
        mem_wa   = cursor_r;
        color_we = mask_r[0];
        color_wd = {mix_r[0], mix_r[1], mix_r[2]};
        depth_we = mask_r[1];
        depth_wd = DEPTH_ONE;
        if (cursor_r == PIX_W'(PIXELS - 1)) begin
          cursor_nxt = '0;
          fin        = 1'b1;
          fin_status = ST_CLEARED;
          state_nxt  = S_IDLE;
        end else begin
          cursor_nxt = cursor_r + 1'b1;
          state_nxt  = S_CLR_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE))
    else $error("result strobe while sequencer active");

  a_cursor_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cursor_r == '0))
    else $error("clear cursor not parked at zero");

  a_read_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_READ) |-> (out_read_color == '0 && out_read_depth == '0))
    else $error("read data present on non-read result");

endmodule
